// File: rtl/psf_pkg.sv
// Package for the paracrystal structure factor block.
// Holds the fixed-point constants and the divisor tables of the Taylor series.
// No dependencies.
`default_nettype none

package psf_pkg;

  // Largest number of layers that the term loop sums over.
  localparam int MAX_TERMS = 64;

  // One in Q30.
  localparam logic [30:0] ONE_Q30       = 31'h4000_0000;
  // Pi/2 in Q30, 1/(2*pi) in Q0.64 and exp(-1) in Q30.
  localparam logic [30:0] HALF_PI_Q30   = 31'd1686629713;
  localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE_60DB_9391_054A;
  localparam logic [30:0] EXP_M1_Q30    = 31'd395007542;

  // Widths of the running sums and of the divider dividend.
  localparam int ACC_W = 48;
  localparam int DVD_W = 45;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SPACING  = 2'd0;
  localparam logic [1:0] CFG_DISORDER = 2'd1;
  localparam logic [1:0] CFG_WHOLE    = 2'd2;
  localparam logic [1:0] CFG_FRACTION = 2'd3;

  // Divisor table: the cosine series uses the first seven entries, the
  // exponential series the remaining twelve.
  localparam int DIV_N = 19;
  localparam logic [4:0] DIV_COS_FIRST = 5'd0;
  localparam logic [4:0] DIV_COS_LAST  = 5'd6;
  localparam logic [4:0] DIV_EXP_FIRST = 5'd7;
  localparam logic [4:0] DIV_EXP_LAST  = 5'd18;

  // Right shift for each divisor: 32 plus the ceiling of its base-2 logarithm.
  localparam logic [5:0] DIV_SHIFT [DIV_N] = '{
    6'd40, 6'd40, 6'd39, 6'd38, 6'd37, 6'd36, 6'd33,
    6'd36, 6'd36, 6'd36, 6'd36, 6'd35, 6'd35, 6'd35, 6'd35, 6'd34, 6'd34, 6'd33, 6'd32
  };

  // Rounded-up reciprocals, so that (v * rcp) >> shift is the exact floor of v / d.
  localparam logic [32:0] DIV_RCP [DIV_N] = '{
    33'(((66'd1 << 40) + 66'd181) / 66'd182),
    33'(((66'd1 << 40) + 66'd131) / 66'd132),
    33'(((66'd1 << 39) + 66'd89) / 66'd90),
    33'(((66'd1 << 38) + 66'd55) / 66'd56),
    33'(((66'd1 << 37) + 66'd29) / 66'd30),
    33'(((66'd1 << 36) + 66'd11) / 66'd12),
    33'(((66'd1 << 33) + 66'd1) / 66'd2),
    33'(((66'd1 << 36) + 66'd11) / 66'd12),
    33'(((66'd1 << 36) + 66'd10) / 66'd11),
    33'(((66'd1 << 36) + 66'd9) / 66'd10),
    33'(((66'd1 << 36) + 66'd8) / 66'd9),
    33'(((66'd1 << 35) + 66'd7) / 66'd8),
    33'(((66'd1 << 35) + 66'd6) / 66'd7),
    33'(((66'd1 << 35) + 66'd5) / 66'd6),
    33'(((66'd1 << 35) + 66'd4) / 66'd5),
    33'(((66'd1 << 34) + 66'd3) / 66'd4),
    33'(((66'd1 << 34) + 66'd2) / 66'd3),
    33'(((66'd1 << 33) + 66'd1) / 66'd2),
    33'(66'd1 << 32)
  };

endpackage

`default_nettype wire

// File: rtl/paracrystal_structure_factor.sv
// Top level of the paracrystal structure factor block: sequencer, shared multiplier,
// serial divider and blend. Depends on psf_pkg.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-----------------------------------
//   input    | in_valid_i / in_ready_o    | projected_q_i (signed Q8.24)
//   result   | out_valid_o / out_ready_i  | structure_factor_o (signed Q16.16)
//   config   | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// Every product goes through the one 32x33 multiplier; each series step passes through
// S_PM, S_PR and S_PS, and the two final divisions run one quotient bit a cycle.
// Reset restores the register defaults and leaves the block idle.
// A finished result waits in the output register; the next item is taken meanwhile
// and stalls only at its final step while the earlier result is still unclaimed.
`default_nettype none

module paracrystal_structure_factor (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [31:0] projected_q_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      structure_factor_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);
  import psf_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_MD   = 5'd1;
  localparam logic [4:0] S_MS   = 5'd2;
  localparam logic [4:0] S_PP0  = 5'd3;
  localparam logic [4:0] S_PP1  = 5'd4;
  localparam logic [4:0] S_PP2  = 5'd5;
  localparam logic [4:0] S_PP3  = 5'd6;
  localparam logic [4:0] S_MG   = 5'd7;
  localparam logic [4:0] S_EX0  = 5'd8;
  localparam logic [4:0] S_PM   = 5'd9;
  localparam logic [4:0] S_PR   = 5'd10;
  localparam logic [4:0] S_PS   = 5'd11;
  localparam logic [4:0] S_EW   = 5'd12;
  localparam logic [4:0] S_EWR  = 5'd13;
  localparam logic [4:0] S_T0   = 5'd14;
  localparam logic [4:0] S_T1   = 5'd15;
  localparam logic [4:0] S_T2   = 5'd16;
  localparam logic [4:0] S_T3   = 5'd17;
  localparam logic [4:0] S_T4   = 5'd18;
  localparam logic [4:0] S_T5   = 5'd19;
  localparam logic [4:0] S_DVA  = 5'd20;
  localparam logic [4:0] S_DVI  = 5'd21;
  localparam logic [4:0] S_DVE  = 5'd22;
  localparam logic [4:0] S_BL0  = 5'd23;
  localparam logic [4:0] S_BL1  = 5'd24;
  localparam logic [4:0] S_BL2  = 5'd25;
  localparam logic [4:0] S_BL3  = 5'd26;

  localparam logic signed [65:0] RES_MAX = 66'sd2147483647;
  localparam logic signed [65:0] RES_MIN = -66'sd2147483648;

  logic [4:0]  state_q, state_d;
  logic [31:0] spacing_q, spacing_d, disorder_q, disorder_d;
  logic [6:0]  whole_q, whole_d;
  logic [15:0] frac_q, frac_d;
  logic        out_valid_q, out_valid_d;
  logic signed [31:0] out_q, out_d;

  logic [31:0]  mag_q, mag_d;
  logic [63:0]  pd_q, pd_d;
  logic [30:0]  m28_q, m28_d;
  logic         big_q, big_d;
  logic [127:0] sum_q, sum_d;
  logic [63:0]  step_q, step_d;
  logic [31:0]  pm_q, pm_d;
  logic [30:0]  pacc_q, pacc_d;
  logic [4:0]   idx_q, idx_d;
  logic         cos_q, cos_d;
  logic [4:0]   wcnt_q, wcnt_d;
  logic [30:0]  e_q, e_d, dk_q, dk_d;
  logic [63:0]  phase_q, phase_d;
  logic [1:0]   quad_q, quad_d;
  logic [7:0]   k_q, k_d, n_q, n_d;
  logic signed [ACC_W-1:0] a_q, a_d, b_q, b_d, last_q, last_d;
  logic [DVD_W-1:0] dq_q, dq_d;
  logic [7:0]   rem_q, rem_d, div_q, div_d;
  logic         qneg_q, qneg_d;
  logic [5:0]   dcnt_q, dcnt_d;
  logic         dsel_q, dsel_d;
  logic signed [ACC_W-1:0] sn_q, sn_d, sn1_q, sn1_d;
  logic [47:0]  dmag_q, dmag_d, lo_q, lo_d;
  logic         dneg_q, dneg_d;
  logic [64:0]  prod_q, prod_d;

  logic [31:0] mul_a;
  logic [32:0] mul_b;

  // Scratch values of the sequencer.
  logic [64:0] shifted;
  logic [30:0] rr;
  logic signed [ACC_W-1:0] p_term, two_x, abs_x, qs;
  logic [8:0]  rn;
  logic        ge;
  logic signed [48:0] diff;
  logic [63:0] wd;
  logic signed [65:0] swd, mix, adj, shq;

  assign in_ready_o         = (state_q == S_IDLE);
  assign cfg_ready_o        = 1'b1;
  assign out_valid_o        = out_valid_q;
  assign structure_factor_o = out_q;

  // Shared multiplier with a registered product.
  assign prod_d = {33'b0, mul_a} * {32'b0, mul_b};

  // Sequencer.
  always_comb begin
    state_d = state_q;
    spacing_d = spacing_q; disorder_d = disorder_q; whole_d = whole_q; frac_d = frac_q;
    out_valid_d = out_valid_q; out_d = out_q;
    mag_d = mag_q; pd_d = pd_q; m28_d = m28_q; big_d = big_q; sum_d = sum_q;
    step_d = step_q; pm_d = pm_q; pacc_d = pacc_q; idx_d = idx_q; cos_d = cos_q;
    wcnt_d = wcnt_q; e_d = e_q; dk_d = dk_q; phase_d = phase_q; quad_d = quad_q;
    k_d = k_q; n_d = n_q; a_d = a_q; b_d = b_q; last_d = last_q;
    dq_d = dq_q; rem_d = rem_q; div_d = div_q; qneg_d = qneg_q; dcnt_d = dcnt_q;
    dsel_d = dsel_q; sn_d = sn_q; sn1_d = sn1_q; dmag_d = dmag_q; lo_d = lo_q;
    dneg_d = dneg_q;
    mul_a = '0;
    mul_b = '0;
    shifted = prod_q >> DIV_SHIFT[idx_q];
    // The quadrant of the freshly advanced phase picks the mirror.
    rr = phase_q[62] ? 31'(ONE_Q30 - {1'b0, phase_q[61:32]}) : {1'b0, phase_q[61:32]};
    p_term = (quad_q[1] ^ quad_q[0]) ? -ACC_W'(prod_q[60:30]) : ACC_W'(prod_q[60:30]);
    two_x = '0;
    abs_x = '0;
    qs = qneg_q ? -ACC_W'(dq_q) : ACC_W'(dq_q);
    rn = {rem_q, dq_q[DVD_W-1]};
    ge = (rn >= {1'b0, div_q});
    diff = 49'(sn1_q) - 49'(sn_q);
    wd = {prod_q[31:0], 32'b0} + {16'b0, lo_q};
    swd = dneg_q ? -66'(wd) : 66'(wd);
    mix = ($signed({{2{sn_q[ACC_W-1]}}, sn_q, 16'b0})) + swd;
    adj = mix[65] ? (mix + 66'sd1073741823) : mix;
    shq = adj >>> 30;

    // Configuration writes.
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SPACING:  spacing_d  = cfg_data_i;
        CFG_DISORDER: disorder_d = cfg_data_i;
        CFG_WHOLE:    whole_d    = cfg_data_i[6:0];
        CFG_FRACTION: frac_d     = cfg_data_i[15:0];
        default: ;
      endcase
    end

    // A waiting result leaves when it is taken.
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mag_d = projected_q_i[31] ? (~projected_q_i + 32'd1) : projected_q_i;
          if (whole_q == 7'd0) n_d = 8'd1;
          else if (int'(whole_q) > MAX_TERMS) n_d = 8'(MAX_TERMS);
          else n_d = {1'b0, whole_q};
          state_d = S_MD;
        end
      end
      S_MD: begin
        mul_a = spacing_q; mul_b = {1'b0, mag_q};
        state_d = S_MS;
      end
      S_MS: begin
        pd_d = prod_q[63:0];
        mul_a = disorder_q; mul_b = {1'b0, mag_q};
        state_d = S_PP0;
      end
      // Phase step: four partial products of D*|t| and 1/(2*pi).
      S_PP0: begin
        big_d = (prod_q[63:12] >= 52'h7000_0000);
        m28_d = prod_q[42:12];
        mul_a = pd_q[31:0]; mul_b = {1'b0, INV_TWO_PI_Q64[31:0]};
        state_d = S_PP1;
      end
      S_PP1: begin
        sum_d = 128'(prod_q);
        mul_a = pd_q[31:0]; mul_b = {1'b0, INV_TWO_PI_Q64[63:32]};
        state_d = S_PP2;
      end
      S_PP2: begin
        sum_d = sum_q + {31'b0, prod_q, 32'b0};
        mul_a = pd_q[63:32]; mul_b = {1'b0, INV_TWO_PI_Q64[31:0]};
        state_d = S_PP3;
      end
      S_PP3: begin
        sum_d = sum_q + {31'b0, prod_q, 32'b0};
        mul_a = pd_q[63:32]; mul_b = {1'b0, INV_TWO_PI_Q64[63:32]};
        state_d = S_MG;
      end
      S_MG: begin
        sum_d = sum_q + {prod_q[63:0], 64'b0};
        mul_a = {1'b0, m28_q}; mul_b = {2'b0, m28_q};
        state_d = S_EX0;
      end
      // Split g into its whole and fractional parts and start the exp series.
      S_EX0: begin
        step_d = sum_q[103:40];
        wcnt_d = prod_q[61:57];
        pm_d = {2'b0, prod_q[56:27]};
        pacc_d = ONE_Q30;
        idx_d = DIV_EXP_FIRST;
        cos_d = 1'b0;
        state_d = S_PM;
      end
      // One series step: acc = 1 - floor((m*acc >> 30) / d).
      S_PM: begin
        mul_a = pm_q; mul_b = {2'b0, pacc_q};
        state_d = S_PR;
      end
      S_PR: begin
        mul_a = prod_q[61:30]; mul_b = DIV_RCP[idx_q];
        state_d = S_PS;
      end
      S_PS: begin
        pacc_d = (shifted >= 65'(ONE_Q30)) ? 31'd0 : 31'(ONE_Q30 - shifted[30:0]);
        if ((cos_q && idx_q == DIV_COS_LAST) || (!cos_q && idx_q == DIV_EXP_LAST)) begin
          state_d = cos_q ? S_T4 : S_EW;
        end else begin
          idx_d = idx_q + 5'd1;
          state_d = S_PM;
        end
      end
      // Whole part of g: one factor of exp(-1) per unit.
      S_EW: begin
        if (wcnt_q == 5'd0) begin
          e_d = big_q ? 31'd0 : pacc_q;
          dk_d = ONE_Q30;
          phase_d = '0;
          k_d = 8'd1;
          a_d = '0; b_d = '0; last_d = '0;
          state_d = S_T0;
        end else begin
          mul_a = {1'b0, pacc_q}; mul_b = {2'b0, EXP_M1_Q30};
          state_d = S_EWR;
        end
      end
      S_EWR: begin
        pacc_d = prod_q[60:30];
        wcnt_d = wcnt_q - 5'd1;
        state_d = S_EW;
      end
      // Term loop: advance phase and decay.
      S_T0: begin
        phase_d = phase_q + step_q;
        mul_a = {1'b0, dk_q}; mul_b = {2'b0, e_q};
        state_d = S_T1;
      end
      S_T1: begin
        dk_d = prod_q[60:30];
        quad_d = phase_q[63:62];
        mul_a = {1'b0, rr}; mul_b = {2'b0, HALF_PI_Q30};
        state_d = S_T2;
      end
      S_T2: begin
        mul_a = {1'b0, prod_q[60:30]}; mul_b = {2'b0, prod_q[60:30]};
        state_d = S_T3;
      end
      S_T3: begin
        pm_d = prod_q[61:30];
        pacc_d = ONE_Q30;
        idx_d = DIV_COS_FIRST;
        cos_d = 1'b1;
        state_d = S_PM;
      end
      S_T4: begin
        mul_a = {1'b0, pacc_q}; mul_b = {2'b0, dk_q};
        state_d = S_T5;
      end
      // Weighted sum kept as a sum of running partial sums.
      S_T5: begin
        if (k_q < n_q) begin
          b_d = b_q + p_term;
          a_d = a_q + b_q + p_term;
        end else begin
          last_d = p_term;
        end
        if (k_q == n_q) state_d = S_DVA;
        else begin
          k_d = k_q + 8'd1;
          state_d = S_T0;
        end
      end
      // Set up 2A / n.
      S_DVA: begin
        two_x = a_q <<< 1;
        abs_x = two_x[ACC_W-1] ? -two_x : two_x;
        qneg_d = two_x[ACC_W-1];
        dq_d = abs_x[DVD_W-1:0];
        rem_d = '0;
        div_d = n_q;
        dcnt_d = 6'(DVD_W);
        dsel_d = 1'b0;
        state_d = S_DVI;
      end
      // Restoring division, one quotient bit a cycle.
      S_DVI: begin
        rem_d = ge ? 8'(rn - {1'b0, div_q}) : rn[7:0];
        dq_d = {dq_q[DVD_W-2:0], ge};
        dcnt_d = dcnt_q - 6'd1;
        if (dcnt_q == 6'd1) state_d = S_DVE;
      end
      S_DVE: begin
        if (!dsel_q) begin
          sn_d = ACC_W'(ONE_Q30) + qs;
          two_x = (a_q + b_q + last_q) <<< 1;
          abs_x = two_x[ACC_W-1] ? -two_x : two_x;
          qneg_d = two_x[ACC_W-1];
          dq_d = abs_x[DVD_W-1:0];
          rem_d = '0;
          div_d = n_q + 8'd1;
          dcnt_d = 6'(DVD_W);
          dsel_d = 1'b1;
          state_d = S_DVI;
        end else begin
          sn1_d = ACC_W'(ONE_Q30) + qs;
          state_d = S_BL0;
        end
      end
      // Blend: S_n * 65536 + w * (S_(n+1) - S_n).
      S_BL0: begin
        dneg_d = diff[48];
        dmag_d = diff[48] ? 48'(-diff) : diff[47:0];
        state_d = S_BL1;
      end
      S_BL1: begin
        mul_a = {16'b0, frac_q}; mul_b = {1'b0, dmag_q[31:0]};
        state_d = S_BL2;
      end
      S_BL2: begin
        lo_d = prod_q[47:0];
        mul_a = {16'b0, frac_q}; mul_b = {17'b0, dmag_q[47:32]};
        state_d = S_BL3;
      end
      S_BL3: begin
        if (!out_valid_q || out_ready_i) begin
          if (shq > RES_MAX) out_d = 32'sh7fff_ffff;
          else if (shq < RES_MIN) out_d = 32'sh8000_0000;
          else out_d = shq[31:0];
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          // Hold the last product while the earlier result waits.
          mul_a = {16'b0, frac_q}; mul_b = {17'b0, dmag_q[47:32]};
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      spacing_q   <= 32'd655360;
      disorder_q  <= 32'd65536;
      whole_q     <= 7'd10;
      frac_q      <= 16'd0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      spacing_q   <= spacing_d;
      disorder_q  <= disorder_d;
      whole_q     <= whole_d;
      frac_q      <= frac_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    out_q <= out_d; mag_q <= mag_d; pd_q <= pd_d; m28_q <= m28_d; big_q <= big_d;
    sum_q <= sum_d; step_q <= step_d; pm_q <= pm_d; pacc_q <= pacc_d; idx_q <= idx_d;
    cos_q <= cos_d; wcnt_q <= wcnt_d; e_q <= e_d; dk_q <= dk_d; phase_q <= phase_d;
    quad_q <= quad_d; k_q <= k_d; n_q <= n_d; a_q <= a_d; b_q <= b_d; last_q <= last_d;
    dq_q <= dq_d; rem_q <= rem_d; div_q <= div_d; qneg_q <= qneg_d; dcnt_q <= dcnt_d;
    dsel_q <= dsel_d; sn_q <= sn_d; sn1_q <= sn1_d; dmag_q <= dmag_d; lo_q <= lo_d;
    dneg_q <= dneg_d; prod_q <= prod_d;
  end

`ifndef SYNTHESIS
  // The series never runs past the end of the divisor table.
  a_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PM) |-> (idx_q <= DIV_EXP_LAST))
    else $error("series divisor index out of range");

  // The term counter stays within the layer count.
  a_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_T0) |-> (k_q >= 8'd1 && k_q <= n_q))
    else $error("term counter outside the layer count");

  // The divider never sees a zero divisor.
  a_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DVI) |-> (div_q != 8'd0))
    else $error("zero divisor in the serial divider");

  // A result appears only from the final blend step.
  a_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_BL3))
    else $error("result raised outside the blend step");
`endif

endmodule

`default_nettype wire

// File: bench/psf_checker.sv
// Checker for the paracrystal structure factor block: it watches the three channels,
// predicts each structure factor from its own copy of the registers and compares.
// Depends on psf_pkg for the register indexes.
`timescale 1ns / 100ps

module psf_checker (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_ready_i,
  input  wire logic signed [31:0] projected_q_i,
  input  wire logic               out_valid_i,
  input  wire logic               out_ready_i,
  input  wire logic signed [31:0] structure_factor_i,
  input  wire logic               cfg_valid_i,
  input  wire logic               cfg_ready_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  output int                      mismatch_count_o,
  output int                      pending_count_o,
  output int                      checked_count_o
);
  import psf_pkg::*;

  localparam int       LAYER_LIMIT = 64;
  localparam bit [63:0] Q30_ONE    = 64'd1 << 30;
  localparam bit [63:0] RAD_QUART  = 64'd1686629713;
  localparam bit [63:0] TURN_RCP   = 64'h28BE_60DB_9391_054A;
  localparam bit [63:0] EXP_M1     = 64'd395007542;

  // Own copy of the configuration registers.
  bit [31:0] spacing_q;
  bit [31:0] disorder_q;
  bit [6:0]  layers_q;
  bit [15:0] fraction_q;

  // Structure factors still to arrive, oldest first.
  logic signed [31:0] factor_queue [$];

  // Cosine of a quarter-turn remainder r in Q30 by a nested Taylor series.
  function automatic bit [63:0] quarter_cosine(bit [63:0] r);
    bit [63:0] divs [6] = '{64'd182, 64'd132, 64'd90, 64'd56, 64'd30, 64'd12};
    bit [63:0] x, x2, acc, v;
    x   = (r * RAD_QUART) >> 30;
    x2  = (x * x) >> 30;
    acc = Q30_ONE;
    for (int i = 0; i < 6; i++) acc = Q30_ONE - ((x2 * acc) >> 30) / divs[i];
    v = ((x2 * acc) >> 30) / 64'd2;
    return (v >= Q30_ONE) ? 64'd0 : Q30_ONE - v;
  endfunction

  // Signed cosine of a phase given in turns, Q0.64.
  function automatic longint turn_cosine(bit [63:0] phase);
    bit [63:0] u, quad, r;
    longint    c;
    u    = phase >> 32;
    quad = u >> 30;
    r    = u & (Q30_ONE - 1);
    if (quad[0]) r = Q30_ONE - r;
    c = longint'(quarter_cosine(r));
    return (quad == 1 || quad == 2) ? -c : c;
  endfunction

  // exp(-g) for g in Q30, split into whole and fractional parts.
  function automatic bit [63:0] neg_exp(bit [63:0] g);
    bit [63:0] whole, f, acc;
    whole = g >> 30;
    f     = g & (Q30_ONE - 1);
    acc   = Q30_ONE;
    if (whole >= 32) return 64'd0;
    for (int n = 12; n >= 1; n--) acc = Q30_ONE - ((f * acc) >> 30) / 64'(n);
    for (int j = 0; j < whole; j++) acc = (acc * EXP_M1) >> 30;
    return acc;
  endfunction

  // Blended structure factor for one projected scattering vector.
  function automatic logic signed [31:0] predict_factor(logic [31:0] raw);
    bit [63:0]  mag, prod, step, m28, e, d, phase, cu;
    bit [127:0] wide;
    longint     n, a, b, last, sn, sn1, mix, res, c, p;
    mag   = raw[31] ? (64'd1 << 32) - 64'(raw) : 64'(raw);
    prod  = 64'(spacing_q) * mag;
    wide  = {64'd0, prod} * {64'd0, TURN_RCP};
    step  = wide[103:40];
    m28   = (64'(disorder_q) * mag) >> 12;
    e     = (m28 >= (64'd7 << 28)) ? 64'd0 : neg_exp((m28 * m28) >> 27);
    d     = Q30_ONE;
    phase = 0;
    a = 0; b = 0; last = 0;
    n = longint'(layers_q);
    if (n < 1) n = 1;
    if (n > LAYER_LIMIT) n = LAYER_LIMIT;
    for (longint k = 1; k <= n; k++) begin
      phase = phase + step;
      d     = (d * e) >> 30;
      c     = turn_cosine(phase);
      if (c >= 0) begin
        cu = 64'(c);
        p  = longint'((cu * d) >> 30);
      end else begin
        cu = 64'(-c);
        p  = -longint'((cu * d) >> 30);
      end
      if (k < n) begin
        a += (n - k) * p;
        b += p;
      end else begin
        last = p;
      end
    end
    sn  = longint'(Q30_ONE) + (2 * a) / n;
    sn1 = longint'(Q30_ONE) + (2 * (a + b + last)) / (n + 1);
    mix = longint'(65536 - int'(fraction_q)) * sn + longint'(fraction_q) * sn1;
    res = mix / longint'(Q30_ONE);
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    return res[31:0];
  endfunction

  // Register writes, predictions on accepted items, comparison on accepted results.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q        <= 32'd655360;
      disorder_q       <= 32'd65536;
      layers_q         <= 7'd10;
      fraction_q       <= 16'd0;
      mismatch_count_o <= 0;
      checked_count_o  <= 0;
      factor_queue.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SPACING:  spacing_q  <= cfg_data_i;
          CFG_DISORDER: disorder_q <= cfg_data_i;
          CFG_WHOLE:    layers_q   <= cfg_data_i[6:0];
          CFG_FRACTION: fraction_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) factor_queue.push_back(predict_factor(projected_q_i));
      if (out_valid_i && out_ready_i) begin
        checked_count_o <= checked_count_o + 1;
        if (factor_queue.size() == 0) begin
          if (mismatch_count_o < 10)
            $display("unexpected result %h with nothing pending", structure_factor_i);
          mismatch_count_o <= mismatch_count_o + 1;
        end else begin
          if (factor_queue[0] !== structure_factor_i) begin
            if (mismatch_count_o < 10)
              $display("structure_factor mismatch: expected %h, got %h",
                       factor_queue[0], structure_factor_i);
            mismatch_count_o <= mismatch_count_o + 1;
          end
          void'(factor_queue.pop_front());
        end
      end
    end
  end

  // Number of structure factors still owed, seen after this edge's updates.
  always_comb pending_count_o = factor_queue.size();

endmodule

// File: bench/tb_top.sv
// Top of the paracrystal structure factor testbench: clock, reset, stimulus and verdict.
// Depends on psf_pkg, the block itself and psf_checker.
`timescale 1ns / 100ps

module tb_top;
  import psf_pkg::*;

  localparam int CYCLE_LIMIT = 15_000_000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] projected_q = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] structure_factor;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  int mismatches, pending, checked;
  int item_count  = 0;
  int phase_count = 0;
  int cycles      = 0;
  bit calm        = 1'b0;

  paracrystal_structure_factor dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .projected_q_i(projected_q),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .structure_factor_o(structure_factor),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  psf_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .projected_q_i(projected_q),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .structure_factor_i(structure_factor),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .mismatch_count_o(mismatches), .pending_count_o(pending), .checked_count_o(checked)
  );

  always #10 clk = ~clk;

  // The receiver stalls at random except in the calm stretch.
  always @(posedge clk) out_ready <= calm || ($urandom_range(99) >= 15);

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("paracrystal_structure_factor test failed");
      $finish;
    end
  end

  // Offers one item, with an occasional gap before it, and returns at its accepting edge.
  task automatic send_item(logic [31:0] value);
    if (!calm && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    projected_q <= value;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    item_count++;
  endtask

  // Writes one register; valid drops once the write has been taken.
  task automatic write_reg(logic [1:0] index, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Holds the sender off until every structure factor has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic set_all(logic [31:0] spacing, logic [31:0] disorder, logic [31:0] whole,
                         logic [31:0] fraction);
    drain();
    write_reg(CFG_SPACING, spacing);
    write_reg(CFG_DISORDER, disorder);
    write_reg(CFG_WHOLE, whole);
    write_reg(CFG_FRACTION, fraction);
    phase_count++;
  endtask

  // A random vector, mostly of small magnitude so the decay stays alive.
  function automatic logic [31:0] random_q();
    logic [31:0] v;
    v = $urandom;
    if ($urandom_range(3) != 0) v = $signed(v) >>> $urandom_range(4, 31);
    return v;
  endfunction

  function automatic logic [31:0] random_wide();
    logic [31:0] v;
    v = $urandom;
    if ($urandom_range(1) != 0) v = v >> $urandom_range(0, 31);
    return v;
  endfunction

  initial begin
    logic [31:0] directed [12] = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
      32'hFFFF_FFFF, 32'h0000_0001, 32'h0100_0000, 32'hFF00_0000, 32'h0080_0000,
      32'h0400_0000, 32'h0001_0000, 32'hF800_0000, 32'h0033_3333};
    int items_left;
    int n_items;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings over the field extremes and a few ordinary vectors.
    foreach (directed[i]) send_item(directed[i]);

    // Register extremes: no and full spacing and disorder, full and zero weight, layer counts one and 64.
    set_all(32'd0, 32'd0, 32'd1, 32'd65535);
    for (int i = 0; i < 4; i++) send_item(directed[i]);
    set_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd64, 32'd0);
    for (int i = 0; i < 3; i++) send_item(directed[i + 2]);
    // Layer count zero counts as one, above the limit as the limit.
    set_all(32'h0002_0000, 32'h0000_4000, 32'd0, 32'd32768);
    send_item(32'h0100_0000);
    send_item(32'h8000_0000);
    set_all(32'h0001_8000, 32'h0000_1000, 32'hFFFF_FF7F, 32'h0000_FFFF);
    send_item(32'h0080_0000);
    send_item(32'h7FFF_FFFF);

    // Random phases, with one calm stretch that has no idling on either side.
    items_left = 1200;
    while (items_left > 0) begin
      logic [31:0] whole;
      whole = {$urandom} & 32'hFFFF_FF80;
      if ($urandom_range(9) == 0) begin
        whole[6:0] = ($urandom_range(1) != 0) ? 7'd64 : 7'($urandom_range(65, 127));
        n_items = 8;
      end else begin
        whole[6:0] = 7'($urandom_range(0, 12));
        n_items = $urandom_range(30, 70);
      end
      set_all(random_wide(), random_wide(), whole, $urandom_range(0, 65535));
      calm = (phase_count == 8);
      for (int i = 0; i < n_items; i++) send_item(random_q());
      calm = 1'b0;
      items_left -= n_items;
    end

    drain();
    repeat (3000) @(posedge clk);
    $display("Sent %0d items over %0d register settings; %0d structure factors checked.",
             item_count, phase_count, checked);
    if (mismatches == 0 && pending == 0) begin
      $display("paracrystal_structure_factor test passed");
    end else begin
      $display("paracrystal_structure_factor test failed");
    end
    $finish;
  end

endmodule
